// ===== rtl/hcbp_pkg.sv =====
// shared types and constants for the huffman code bit packer
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

   // table geometry
   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int TBL_AW       = $clog2(SYMBOL_COUNT);

   // field widths
   localparam int SYM_W  = 8;
   localparam int CODE_W = 32;
   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;
   localparam int ACC_W  = 40;
   localparam int FILL_W = 6;
   localparam int OP_W   = 2;

   // longest code that is kept in the table
   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   // opcodes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

   // byte kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_PAD  = 1'b1;

   // one code table entry
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } code_entry_type;

   // item handed from the lookup stage to the packer
   typedef struct packed {
      logic              flush;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } pk_item_type;

   // packer status back to the lookup stage
   typedef struct packed {
      logic              ready;
      logic [FILL_W-1:0] fill;
   } pk_status_type;

   // flush sequencer states
   typedef enum logic [1:0] {
      FL_IDLE,
      FL_DATA,
      FL_PAD
   } flush_state_type;

endpackage

`default_nettype wire

// ===== rtl/hcbp_code_table.sv =====
// code table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hcbp_code_table import hcbp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [TBL_AW-1:0] wr_addr,
   input  wire code_entry_type    wr_data,
   input  wire logic              rd_en,
   input  wire logic [TBL_AW-1:0] rd_addr,
   output code_entry_type         rd_data
);

   code_entry_type mem_ff [SYMBOL_COUNT];
   code_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/hcbp_packer.sv =====
// bit accumulator, byte drain, flush sequencer and output register
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer import hcbp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire pk_item_type       item,
   output pk_status_type          status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_byte_kind,
   output logic                   rsp_last
);

   localparam logic [FILL_W-1:0] FILL_BYTE = FILL_W'(BYTE_W);
   localparam logic [FILL_W-1:0] FILL_TWO  = FILL_W'(2 * BYTE_W);

   flush_state_type     fstate_ff, fstate_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic                rsp_kind_ff;
   logic                rsp_last_ff;

   logic                busy;
   logic                take;
   logic                out_free;
   logic                emit;
   logic [BYTE_W-1:0]   emit_byte;
   logic                emit_kind;
   logic                emit_last;
   logic                drop;
   logic                clear;
   logic [2:0]          pad;

   // handshake with the lookup stage and the output register
   assign busy     = (fstate_ff != FL_IDLE) || (fill_ff > FILL_BYTE);
   assign take     = item_valid && !busy;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pad      = 3'(4'd8 - {1'b0, fill_ff[2:0]});

   // flush sequencer next state
   always_comb begin
      fstate_in = fstate_ff;
      case (fstate_ff)
         FL_IDLE: begin
            if (take && item.flush && (fill_ff != '0)) fstate_in = FL_DATA;
         end
         FL_DATA: begin
            if (out_free) fstate_in = FL_PAD;
         end
         FL_PAD: begin
            if (out_free) fstate_in = FL_IDLE;
         end
         default: fstate_in = FL_IDLE;
      endcase
   end

   // byte emission
   always_comb begin
      emit      = 1'b0;
      emit_byte = acc_ff[BYTE_W-1:0];
      emit_kind = KIND_DATA;
      emit_last = 1'b0;
      drop      = 1'b0;
      clear     = 1'b0;
      case (fstate_ff)
         FL_IDLE: begin
            if ((fill_ff > FILL_BYTE) && out_free) begin
               emit      = 1'b1;
               emit_last = (fill_ff <= FILL_TWO);
               drop      = 1'b1;
            end
         end
         FL_DATA: begin
            if (out_free) emit = 1'b1;
         end
         FL_PAD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = {{(BYTE_W-3){1'b0}}, pad};
               emit_kind = KIND_PAD;
               emit_last = 1'b1;
               clear     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // accumulator update
   always_comb begin
      acc_in  = acc_ff;
      fill_in = fill_ff;
      if (clear) begin
         acc_in  = '0;
         fill_in = '0;
      end else if (drop) begin
         acc_in  = acc_ff >> BYTE_W;
         fill_in = fill_ff - FILL_BYTE;
      end else if (take && !item.flush) begin
         acc_in  = acc_ff | (ACC_W'(item.code) << fill_ff[3:0]);
         fill_in = fill_ff + FILL_W'(item.len);
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff    <= FL_IDLE;
         acc_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fstate_ff    <= fstate_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_kind_ff <= emit_kind;
         rsp_last_ff <= emit_last;
      end
   end

   assign status.ready  = !busy;
   assign status.fill   = fill_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_byte_kind = rsp_kind_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/huffman_code_bit_packer.sv =====
// top level of the huffman code bit packer: request decode and table lookup
`timescale 1ns / 1ps
`default_nettype none

// Huffman encoder back end. A load beat writes one symbol's code (bits, length
// saturated to 32, bits above the length cleared) into a 256-entry code table;
// an encode beat looks the symbol up and appends its code LSB-first to a 40-bit
// accumulator, and whole bytes leave once more than 8 bits are pending; a flush
// beat with bits pending emits the zero-padded last byte and then a pad count
// byte. Encoding a symbol whose entry was never loaded gives undefined bytes.
// The packer drains one byte per cycle into a single output register while
// the output is not stalled. The table is read once per encode, when the request
// is accepted, and its read register holds the entry until the packer takes it,
// so a load followed directly by an encode of the same symbol sees the new code.
module huffman_code_bit_packer import hcbp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [SYM_W-1:0]  req_symbol,
   input  wire logic [CODE_W-1:0] req_code_bits,
   input  wire logic [LEN_W-1:0]  req_code_length,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_byte_kind,
   output logic                   rsp_last
);

   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(LEN_CAP);

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_flush_ff;
   logic              accept;
   logic              in_range;
   logic              is_load;
   logic              is_encode;
   logic              is_flush;
   logic [LEN_W-1:0]  cap_len;
   code_entry_type    wr_entry;
   code_entry_type    rd_entry;
   pk_item_type       pk_item;
   pk_status_type     pk_status;

   // request decode
   assign accept    = req_valid && !req_stall;
   assign in_range  = (int'(req_symbol) < SYMBOL_COUNT);
   assign is_load   = (req_opcode == OP_LOAD);
   assign is_encode = (req_opcode == OP_ENCODE);
   assign is_flush  = (req_opcode == OP_FLUSH);
   assign req_stall = s1_valid_ff && !pk_status.ready;

   // saturate length and clear code bits above it
   always_comb begin
      cap_len = (req_code_length > CAP_LEN) ? CAP_LEN : req_code_length;
      wr_entry.len = cap_len;
      for (int i = 0; i < CODE_W; i++) begin
         wr_entry.bits[i] = req_code_bits[i] && (LEN_W'(i) < cap_len);
      end
   end

   hcbp_code_table u_table (
      .clock   (clock),
      .wr_en   (accept && is_load && in_range),
      .wr_addr (req_symbol[TBL_AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (accept && is_encode && in_range),
      .rd_addr (req_symbol[TBL_AW-1:0]),
      .rd_data (rd_entry)
   );

   // lookup stage holds an encode or flush until the packer takes it
   always_comb begin
      if (accept) s1_valid_in = (is_encode && in_range) || is_flush;
      else s1_valid_in = s1_valid_ff && !pk_status.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flush_ff <= is_flush;
      end
   end

   assign pk_item.flush = s1_flush_ff;
   assign pk_item.code  = rd_entry.bits;
   assign pk_item.len   = rd_entry.len;

   hcbp_packer u_packer (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (s1_valid_ff),
      .item          (pk_item),
      .status        (pk_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_byte_kind (rsp_byte_kind),
      .rsp_last      (rsp_last)
   );

   // accumulator never holds more than one byte plus the longest code
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      pk_status.fill <= FILL_W'(BYTE_W + LEN_CAP))
      else $error("bit fill out of range");

   // a pad count byte always closes its flush
   a_pad_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_kind == KIND_PAD) |-> rsp_last)
      else $error("pad count byte not marked last");

   // pad count stays below a byte
   a_pad_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_kind == KIND_PAD) |-> (rsp_out_byte < BYTE_W'(8)))
      else $error("pad count out of range");

   // the lookup stage only waits while the packer is busy
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !pk_status.ready && s1_valid_ff)
      else $error("request stalled with packer ready");

endmodule

`default_nettype wire
